// File: rtl/core/lph_pkg.sv
package lph_pkg;

   // Fixed field widths of the request and response beats.
   localparam int KEY_BITS      = 31;
   localparam int VALUE_IO_BITS = 44;

   // Defaults for the top-level parameters.
   localparam int TABLE_SIZE_DEFAULT = 1024;
   localparam int VALUE_BITS_DEFAULT = 44;

   // Request opcodes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_EVAL
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear_step;   // write an empty word at the sweep address
      logic load;         // capture the request beat
      logic mod_step;     // one step of the home-slot reduction
      logic start_probe;  // load the home slot from the reduced key
      logic read;         // read the current slot
      logic advance;      // step to the next slot with wrap
      logic write;        // store the request at the current slot
      logic respond;      // load the response register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic pow2;         // table size is a power of two: home slot known at load
      logic clear_last;   // sweep address is the final slot
      logic mod_done;     // home-slot reduction finished
      logic is_insert;    // captured opcode is an insert
      logic slot_empty;   // slot just read holds nothing
      logic key_match;    // slot just read is occupied with the same key
      logic last_probe;   // slot just read completes one full pass
      logic out_free;     // response register can take a new beat this cycle
   } stat_type;

endpackage

// File: rtl/core/linear_probe_hash_table_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid / req_stall  req_opcode, req_key, req_value
// rsp_      out        rsp_valid / rsp_stall  rsp_found, rsp_result_value, rsp_status
//
// One request is in flight at a time; req_stall is low only while idle.
// With a power-of-two table the home slot is taken from the key at the
// accepting edge; each probed slot is read and then evaluated on the single
// slot memory, and the response register loads from the final evaluate.
// Other sizes first reduce the key (reciprocal multiply, multiply back and
// subtract, final compare and subtract) before the first read.
// After reset the slot memory is swept empty, one slot a cycle, with
// req_stall high.
// A response waiting under rsp_stall holds the block in its final probe
// until the register frees; an earlier response never blocks a new accept.
module linear_probe_hash_table_top #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEFAULT,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [lph_pkg::KEY_BITS-1:0]       req_key,
   input  logic [lph_pkg::VALUE_IO_BITS-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [lph_pkg::VALUE_IO_BITS-1:0]  rsp_result_value,
   output logic                               rsp_status
);

   lph_pkg::cmd_type  cmd;   // controller commands
   lph_pkg::stat_type stat;  // datapath flags

   // Sequencer: clearing sweep, key reduction, probe loop, response hand-off
   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Slot memory ({valid, key, value} per word), probe pointer, response beat
   lph_dp #(
      .TABLE_SIZE (TABLE_SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

// File: rtl/core/lph_ram.sv
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lph_ctrl.sv
module lph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lph_pkg::stat_type stat,
   output lph_pkg::cmd_type  cmd
);

   lph_pkg::state_type state_ff;
   lph_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lph_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lph_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = lph_pkg::ST_IDLE;
            end
         end
         lph_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.pow2 ? lph_pkg::ST_READ : lph_pkg::ST_MOD;
            end
         end
         lph_pkg::ST_MOD: begin
            if (stat.mod_done) begin
               state_in = lph_pkg::ST_READ;
            end
         end
         lph_pkg::ST_READ: begin
            state_in = lph_pkg::ST_EVAL;
         end
         lph_pkg::ST_EVAL: begin
            if (stat.is_insert) begin
               if (stat.slot_empty || stat.last_probe) begin
                  if (stat.out_free) begin
                     state_in = lph_pkg::ST_IDLE;
                  end
               end else begin
                  state_in = lph_pkg::ST_READ;
               end
            end else begin
               if (stat.slot_empty || stat.key_match || stat.last_probe) begin
                  if (stat.out_free) begin
                     state_in = lph_pkg::ST_IDLE;
                  end
               end else begin
                  state_in = lph_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = lph_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         lph_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         lph_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lph_pkg::ST_MOD: begin
            cmd.mod_step    = !stat.mod_done;
            cmd.start_probe = stat.mod_done;
         end
         lph_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         lph_pkg::ST_EVAL: begin
            if (stat.is_insert) begin
               if (stat.slot_empty || stat.last_probe) begin
                  cmd.respond = stat.out_free;
                  cmd.write   = stat.out_free && stat.slot_empty;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else begin
               if (stat.slot_empty || stat.key_match || stat.last_probe) begin
                  cmd.respond = stat.out_free;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/lph_dp.sv
module lph_dp #(
   parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEFAULT,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lph_pkg::cmd_type                   cmd,
   output lph_pkg::stat_type                  stat,
   input  logic                               req_opcode,
   input  logic [lph_pkg::KEY_BITS-1:0]       req_key,
   input  logic [lph_pkg::VALUE_IO_BITS-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [lph_pkg::VALUE_IO_BITS-1:0]  rsp_result_value,
   output logic                               rsp_status
);

   localparam int  KB        = lph_pkg::KEY_BITS;
   localparam int  SLOT_BITS = $clog2(TABLE_SIZE);
   localparam int  CNT_BITS  = $clog2(TABLE_SIZE + 1);
   localparam int  WORD_BITS = 1 + KB + VALUE_BITS;
   localparam bit  IS_POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   // Reciprocal reduction: floor(key * RECIP / 2**KB) is the quotient or one
   // short of it, so key minus estimate times size stays below twice the size.
   localparam logic [63:0]   RECIP_W = (64'd1 << KB) / 64'(TABLE_SIZE);
   localparam logic [KB-1:0] RECIP   = RECIP_W[KB-1:0];
   localparam logic [KB-1:0] SIZE_K  = KB'(TABLE_SIZE);
   localparam logic [1:0]    MOD_STEPS = 2'd2;  // first step forms the estimate
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TABLE_SIZE - 1);
   localparam logic [CNT_BITS-1:0]  PROBE_LAST = CNT_BITS'(TABLE_SIZE - 1);

   // Captured request
   logic                  op_ff;
   logic [KB-1:0]         key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   // Home-slot reduction
   logic [2*KB-1:0]       prod_ff, prod_in;
   logic [KB-1:0]         quot;
   logic [2*KB-1:0]       back_prod;
   logic [KB-1:0]         rem_ff,  rem_in;
   logic [KB-1:0]         rem_fix;
   logic [1:0]            mcnt_ff, mcnt_in;

   // Probe walk and clearing sweep
   logic [SLOT_BITS-1:0]  slot_ff, slot_in, slot_next;
   logic [CNT_BITS-1:0]   probe_ff, probe_in;
   logic [SLOT_BITS-1:0]  clr_ff,  clr_in;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            found_ff;
   logic [lph_pkg::VALUE_IO_BITS-1:0] result_ff;
   logic                            status_ff;

   // Memory port signals
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [WORD_BITS-1:0]  rd_data;
   logic                  rd_valid;
   logic [KB-1:0]         rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   function automatic logic [SLOT_BITS-1:0] slot_next_clr(input logic [SLOT_BITS-1:0] s);
      slot_next_clr = (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   lph_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign rd_valid = rd_data[WORD_BITS-1];
   assign rd_key   = rd_data[WORD_BITS-2 -: KB];
   assign rd_value = rd_data[VALUE_BITS-1:0];

   assign wr_en   = cmd.clear_step || cmd.write;
   assign wr_addr = cmd.clear_step ? clr_ff : slot_ff;
   assign wr_data = cmd.clear_step ? '0 : {1'b1, key_ff, val_ff};

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= VALUE_BITS'(req_value);
      end
   end

   // Reduction: estimate, multiply back and subtract, final compare
   assign quot      = prod_ff[2*KB-1:KB];
   assign back_prod = (2*KB)'(quot) * (2*KB)'(SIZE_K);
   assign rem_fix   = (rem_ff >= SIZE_K) ? rem_ff - SIZE_K : rem_ff;

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      mcnt_in = mcnt_ff;
      if (cmd.load) begin
         mcnt_in = MOD_STEPS;
      end else if (cmd.mod_step) begin
         if (mcnt_ff == MOD_STEPS) begin
            prod_in = (2*KB)'(key_ff) * (2*KB)'(RECIP);
         end else begin
            rem_in = key_ff - back_prod[KB-1:0];
         end
         mcnt_in = mcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      if (reset) begin
         mcnt_ff <= '0;
      end else begin
         mcnt_ff <= mcnt_in;
      end
   end

   // Probe walk
   assign slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   always_comb begin
      slot_in  = slot_ff;
      probe_in = probe_ff;
      if (cmd.load) begin
         slot_in  = IS_POW2 ? req_key[SLOT_BITS-1:0] : '0;
         probe_in = '0;
      end else if (cmd.start_probe) begin
         slot_in  = rem_fix[SLOT_BITS-1:0];
         probe_in = '0;
      end else if (cmd.advance) begin
         slot_in  = slot_next;
         probe_in = probe_ff + 1'b1;
      end
   end

   assign clr_in = cmd.clear_step ? slot_next_clr(clr_ff) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         probe_ff <= '0;
         clr_ff   <= '0;
      end else begin
         slot_ff  <= slot_in;
         probe_ff <= probe_in;
         clr_ff   <= clr_in;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         if (op_ff == lph_pkg::OP_INSERT) begin
            found_ff  <= !rd_valid;
            result_ff <= '0;
            status_ff <= rd_valid ? lph_pkg::STATUS_FULL : lph_pkg::STATUS_OK;
         end else begin
            found_ff  <= stat.key_match;
            result_ff <= stat.key_match ? lph_pkg::VALUE_IO_BITS'(rd_value) : '0;
            status_ff <= lph_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;

   // Status back to the controller
   assign stat.pow2       = IS_POW2;
   assign stat.clear_last = clr_ff == SLOT_LAST;
   assign stat.mod_done   = mcnt_ff == '0;
   assign stat.is_insert  = op_ff == lph_pkg::OP_INSERT;
   assign stat.slot_empty = !rd_valid;
   assign stat.key_match  = rd_valid && (rd_key == key_ff);
   assign stat.last_probe = probe_ff == PROBE_LAST;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule
